@@ sv/tccc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_pkg
// Shared types and constants of the tilt-compensated compass heading core.
// ----------------------------------------------------------------------------
package tccc_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned TURN_W       = 32;
  localparam int unsigned CORDIC_ITERS = 32;
  localparam int unsigned PRESCALE_W   = 30;
  localparam int unsigned CORDIC_W     = 33;

  localparam logic [TURN_W-1:0] TURN_HALF = 32'h8000_0000;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GRAVITY_NORM = 1'b0,
    CFG_MIN_EAST_NORM    = 1'b1
  } cfg_reg_e;

  // One accelerometer / magnetometer sample pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
    logic signed [SAMPLE_W-1:0] mx;
    logic signed [SAMPLE_W-1:0] my;
    logic signed [SAMPLE_W-1:0] mz;
  } sample_t;

  // Per-item flags that travel alongside the angle datapath
  typedef struct packed {
    logic degenerate;
    logic zero;
    logic x_neg;
    logic y_neg;
  } flags_t;

  // Arctangent table, fraction of a turn scaled by 2^32
  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

@@ sv/tccc_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_ifs
// Valid/ready channels for sample pairs in and headings out.
// ----------------------------------------------------------------------------
interface tccc_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  accel_x;
  logic signed [15:0]  accel_y;
  logic signed [15:0]  accel_z;
  logic signed [15:0]  field_x;
  logic signed [15:0]  field_y;
  logic signed [15:0]  field_z;

  modport source (output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                  output ready);
endinterface

interface tccc_out_if #(parameter int unsigned HEAD_W = 16);
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] heading;
  logic              degenerate;

  modport source (output valid, heading, degenerate, input ready);
  modport sink   (input valid, heading, degenerate, output ready);
endinterface

@@ sv/tccc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_front
// Eight-stage vector front end: cross products, norm tests, operand prescale.
// ----------------------------------------------------------------------------
module tccc_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  tccc_pkg::sample_t                     sample_i,
  input  logic [tccc_pkg::CFG_DATA_W-1:0]       min_gravity_i,
  input  logic [tccc_pkg::CFG_DATA_W-1:0]       min_east_i,
  output logic                                  valid_o,
  output logic [tccc_pkg::PRESCALE_W-1:0]       x_o,
  output logic [tccc_pkg::PRESCALE_W-1:0]       y_o,
  output tccc_pkg::flags_t                      flags_o
);

  // number of significant bits above the prescale limit
  function automatic logic [4:0] top_len(input logic [17:0] v);
    logic [4:0] n;
    n = '0;
    for (int k = 0; k < 18; k++) begin
      if (v[k]) n = 5'(k + 1);
    end
    return n;
  endfunction

  // threshold squares, refreshed from the registers every cycle
  logic [31:0] tg2_q, te2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tg2_q <= 32'd1;
      te2_q <= 32'd1;
    end else begin
      tg2_q <= 32'(min_gravity_i) * 32'(min_gravity_i);
      te2_q <= 32'(min_east_i) * 32'(min_east_i);
    end
  end

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  // stage 1: capture the beat
  tccc_pkg::sample_t s1_q;

  // stage 2: products
  logic signed [31:0] myaz_q, mzay_q, mzax_q, mxaz_q, mxay_q, myax_q;
  logic signed [31:0] sqx_q, sqy_q, sqz_q;
  logic signed [15:0] s2_ax_q, s2_az_q;

  // stage 3: cross product and gravity square
  logic signed [32:0] ex_q, ey_q, ez_q;
  logic [31:0]        g2_q;
  logic signed [15:0] s3_ax_q, s3_az_q;

  // stage 4: magnitudes, north products, gravity test
  logic [31:0]        mex_q, mey_q, mez_q, s4_g2_q;
  logic signed [48:0] azex_q, axez_q;
  logic               s4_gdeg_q, s4_yneg_q, s4_yzero_q;

  // stage 5: squares and scaled threshold
  logic [63:0]        e2x_q, e2y_q, e2z_q, te2g2_q;
  logic signed [48:0] ny_q;
  logic [31:0]        s5_mey_q;
  logic               s5_gdeg_q, s5_yneg_q, s5_yzero_q;

  // stage 6: east test and angle operands
  logic [47:0]        ux_q, uy_q;
  tccc_pkg::flags_t   s6_flags_q;

  // stage 7: prescale amount
  logic [4:0]         sh_q;
  logic [47:0]        s7_ux_q, s7_uy_q;
  tccc_pkg::flags_t   s7_flags_q;

  // stage 8: prescaled operands
  logic [tccc_pkg::PRESCALE_W-1:0] x8_q, y8_q;
  tccc_pkg::flags_t   s8_flags_q;

  logic [63:0]        e2_sum;
  logic [47:0]        ux_x, uy_x;
  assign e2_sum = e2x_q + e2y_q + e2z_q;
  assign ux_x   = s7_ux_q >> sh_q;
  assign uy_x   = s7_uy_q >> sh_q;

  // advance the valid bits together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q} <= '0;
    end else if (en_i) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q} <=
        {valid_i, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q};
    end
  end

  // datapath, frozen while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= sample_i;

      myaz_q  <= 32'(s1_q.my) * 32'(s1_q.az);
      mzay_q  <= 32'(s1_q.mz) * 32'(s1_q.ay);
      mzax_q  <= 32'(s1_q.mz) * 32'(s1_q.ax);
      mxaz_q  <= 32'(s1_q.mx) * 32'(s1_q.az);
      mxay_q  <= 32'(s1_q.mx) * 32'(s1_q.ay);
      myax_q  <= 32'(s1_q.my) * 32'(s1_q.ax);
      sqx_q   <= 32'(s1_q.ax) * 32'(s1_q.ax);
      sqy_q   <= 32'(s1_q.ay) * 32'(s1_q.ay);
      sqz_q   <= 32'(s1_q.az) * 32'(s1_q.az);
      s2_ax_q <= s1_q.ax;
      s2_az_q <= s1_q.az;

      ex_q    <= 33'(myaz_q) - 33'(mzay_q);
      ey_q    <= 33'(mzax_q) - 33'(mxaz_q);
      ez_q    <= 33'(mxay_q) - 33'(myax_q);
      g2_q    <= $unsigned(sqx_q) + $unsigned(sqy_q) + $unsigned(sqz_q);
      s3_ax_q <= s2_ax_q;
      s3_az_q <= s2_az_q;

      mex_q      <= 32'(ex_q[32] ? -ex_q : ex_q);
      mey_q      <= 32'(ey_q[32] ? -ey_q : ey_q);
      mez_q      <= 32'(ez_q[32] ? -ez_q : ez_q);
      azex_q     <= 49'(s3_az_q) * 49'(ex_q);
      axez_q     <= 49'(s3_ax_q) * 49'(ez_q);
      s4_g2_q    <= g2_q;
      s4_gdeg_q  <= g2_q < tg2_q;
      s4_yneg_q  <= ey_q[32];
      s4_yzero_q <= ey_q == '0;

      e2x_q      <= 64'(mex_q) * 64'(mex_q);
      e2y_q      <= 64'(mey_q) * 64'(mey_q);
      e2z_q      <= 64'(mez_q) * 64'(mez_q);
      te2g2_q    <= 64'(te2_q) * 64'(s4_g2_q);
      ny_q       <= azex_q - axez_q;
      s5_mey_q   <= mey_q;
      s5_gdeg_q  <= s4_gdeg_q;
      s5_yneg_q  <= s4_yneg_q;
      s5_yzero_q <= s4_yzero_q;

      ux_q                  <= 48'(ny_q[48] ? -ny_q : ny_q);
      uy_q                  <= 48'(s5_mey_q);
      s6_flags_q.degenerate <= s5_gdeg_q | (e2_sum < te2g2_q);
      s6_flags_q.zero       <= s5_yzero_q & (ny_q == '0);
      s6_flags_q.x_neg      <= ny_q[48];
      s6_flags_q.y_neg      <= s5_yneg_q;

      sh_q       <= top_len(ux_q[47:30] | uy_q[47:30]);
      s7_ux_q    <= ux_q;
      s7_uy_q    <= uy_q;
      s7_flags_q <= s6_flags_q;

      x8_q       <= ux_x[tccc_pkg::PRESCALE_W-1:0];
      y8_q       <= uy_x[tccc_pkg::PRESCALE_W-1:0];
      s8_flags_q <= s7_flags_q;
    end
  end

  assign valid_o = v8_q;
  assign x_o     = x8_q;
  assign y_o     = y8_q;
  assign flags_o = s8_flags_q;

endmodule

@@ sv/tccc_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_cordic
// Vectoring CORDIC, one register stage per iteration, angle in turns.
// ----------------------------------------------------------------------------
module tccc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [tccc_pkg::PRESCALE_W-1:0]     x_i,
  input  logic [tccc_pkg::PRESCALE_W-1:0]     y_i,
  input  tccc_pkg::flags_t                    flags_i,
  output logic                                valid_o,
  output logic [tccc_pkg::TURN_W-1:0]         turn_o,
  output tccc_pkg::flags_t                    flags_o
);

  localparam int unsigned N = tccc_pkg::CORDIC_ITERS;
  localparam int unsigned W = tccc_pkg::CORDIC_W;

  logic signed [W-1:0]              cx [N+1];
  logic signed [W-1:0]              cy [N+1];
  logic [tccc_pkg::TURN_W-1:0]      z  [N+1];
  logic                             v  [N+1];
  tccc_pkg::flags_t                 fl [N+1];

  assign cx[0] = W'(x_i);
  assign cy[0] = W'(y_i);
  assign z[0]  = '0;
  assign v[0]  = valid_i;
  assign fl[0] = flags_i;

  for (genvar i = 0; i < N; i++) begin : g_iter
    // advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[i+1] <= 1'b0;
      end else if (en_i) begin
        v[i+1] <= v[i];
      end
    end

    // rotate towards the x axis and accumulate the angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy[i][W-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          z[i+1]  <= z[i] + tccc_pkg::ATAN_TURNS[i];
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          z[i+1]  <= z[i] - tccc_pkg::ATAN_TURNS[i];
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  assign valid_o = v[N];
  assign turn_o  = z[N];
  assign flags_o = fl[N];

endmodule

@@ sv/tccc_obuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_obuf
// Two-entry output buffer; decouples the pipeline stall from the sink.
// ----------------------------------------------------------------------------
module tccc_obuf #(
  parameter int unsigned W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         space_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign data_o  = mem_q[rd_q];

  // track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop)    rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ sv/tilt_compensated_compass_heading_core.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle unless stalled; the front end feeds a 32-stage CORDIC pipeline.
// The whole pipeline freezes only while the two-entry output buffer is full.
// Reset: asynchronous, active low; clears valid bits and loads both
// thresholds with 1.
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_core
// Tilt-compensated compass heading from accelerometer and magnetometer beats.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_core #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  tccc_in_if.sink                              in_i,
  tccc_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [tccc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tccc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  logic [tccc_pkg::CFG_DATA_W-1:0] min_gravity_q, min_east_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gravity_q <= 16'd1;
      min_east_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (tccc_pkg::cfg_reg_e'(cfg_idx_i))
        tccc_pkg::CFG_MIN_GRAVITY_NORM: min_gravity_q <= cfg_wdata_i;
        tccc_pkg::CFG_MIN_EAST_NORM:    min_east_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic              en;
  tccc_pkg::sample_t sample;

  assign in_i.ready = en;
  assign sample = '{ax: in_i.accel_x, ay: in_i.accel_y, az: in_i.accel_z,
                    mx: in_i.field_x, my: in_i.field_y, mz: in_i.field_z};

  logic                              f_valid;
  logic [tccc_pkg::PRESCALE_W-1:0]   f_x, f_y;
  tccc_pkg::flags_t                  f_flags;

  tccc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_i.valid),
    .sample_i      (sample),
    .min_gravity_i (min_gravity_q),
    .min_east_i    (min_east_q),
    .valid_o       (f_valid),
    .x_o           (f_x),
    .y_o           (f_y),
    .flags_o       (f_flags)
  );

  logic                          c_valid;
  logic [tccc_pkg::TURN_W-1:0]   c_turn;
  tccc_pkg::flags_t              c_flags;

  tccc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .x_i     (f_x),
    .y_i     (f_y),
    .flags_i (f_flags),
    .valid_o (c_valid),
    .turn_o  (c_turn),
    .flags_o (c_flags)
  );

  // restore the quadrant from the operand signs
  logic [tccc_pkg::TURN_W-1:0] ang;
  always_comb begin
    case ({c_flags.x_neg, c_flags.y_neg})
      2'b00:   ang = c_turn;
      2'b10:   ang = tccc_pkg::TURN_HALF - c_turn;
      2'b11:   ang = tccc_pkg::TURN_HALF + c_turn;
      default: ang = '0 - c_turn;
    endcase
  end

  // round half up to the output resolution, wrapping at one turn
  logic [ANGLE_BITS-1:0] head_r, head;
  if (ANGLE_BITS < tccc_pkg::TURN_W) begin : g_round
    logic [tccc_pkg::TURN_W:0] sum;
    assign sum    = {1'b0, ang} + ((tccc_pkg::TURN_W + 1)'(1) <<
                                   (tccc_pkg::TURN_W - 1 - ANGLE_BITS));
    assign head_r = sum[tccc_pkg::TURN_W-1 -: ANGLE_BITS];
  end else begin : g_full
    assign head_r = ang[ANGLE_BITS-1:0];
  end

  assign head = (c_flags.degenerate | c_flags.zero) ? '0 : head_r;

  logic                  ob_valid;
  logic [ANGLE_BITS:0]   ob_data;

  tccc_obuf #(.W(ANGLE_BITS + 1)) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en & c_valid),
    .data_i  ({c_flags.degenerate, head}),
    .space_o (en),
    .valid_o (ob_valid),
    .ready_i (out_o.ready),
    .data_o  (ob_data)
  );

  assign out_o.valid      = ob_valid;
  assign out_o.heading    = ob_data[ANGLE_BITS-1:0];
  assign out_o.degenerate = ob_data[ANGLE_BITS];

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample pairs into the compass heading core and checks every heading
// beat against a built-in integer/CORDIC predictor. A directed table comes
// first, then again under zero thresholds, then random beats under several
// threshold settings, random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [15:0] heading;
    logic        degenerate;
  } heading_t;

  typedef struct {
    tccc_pkg::sample_t smp;
    logic     chk;       // typed-in expectation applies
    heading_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tccc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tccc_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  tccc_in_if in_if ();
  tccc_out_if #(.HEAD_W(16)) out_if ();

  tilt_compensated_compass_heading_core #(.ANGLE_BITS(16)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [15:0] grav_min;
  logic [15:0] east_min;
  heading_t    heading_q[$];
  int          errors;
  bit          no_idle;
  int          hold_off;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  // Fraction of a turn for the vector (x, y)
  function automatic logic [31:0] cordic_turn(longint x, longint y);
    longint ux, uy, cx, cy, nx;
    logic [31:0] z;
    z  = '0;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    while (ux >= (64'sd1 << 30) || uy >= (64'sd1 << 30)) begin
      ux = ux >> 1;
      uy = uy >> 1;
    end
    cx = ux;
    cy = uy;
    for (int i = 0; i < tccc_pkg::CORDIC_ITERS; i++) begin
      if (cy >= 0) begin
        nx = cx + floor_sh(cy, i);
        cy = cy - floor_sh(cx, i);
        z  = z + tccc_pkg::ATAN_TURNS[i];
      end else begin
        nx = cx - floor_sh(cy, i);
        cy = cy + floor_sh(cx, i);
        z  = z - tccc_pkg::ATAN_TURNS[i];
      end
      cx = nx;
    end
    if (x >= 0 && y >= 0) return z;
    if (x < 0 && y >= 0) return tccc_pkg::TURN_HALF - z;
    if (x < 0) return tccc_pkg::TURN_HALF + z;
    return 32'd0 - z;
  endfunction

  function automatic heading_t predict_heading(tccc_pkg::sample_t s);
    longint ax, ay, az, mx, my, mz, ex, ey, ez, ny;
    logic [127:0] g2, e2, tg2, te2;
    logic [31:0] ang;
    logic [32:0] rnd;
    heading_t r;
    ax = s.ax; ay = s.ay; az = s.az;
    mx = s.mx; my = s.my; mz = s.mz;
    g2  = 128'(ax * ax + ay * ay + az * az);
    tg2 = 128'(grav_min) * 128'(grav_min);
    ex = my * az - mz * ay;
    ey = mz * ax - mx * az;
    ez = mx * ay - my * ax;
    e2 = 128'(ex * ex) + 128'(ey * ey) + 128'(ez * ez);
    te2 = 128'(east_min) * 128'(east_min);
    if (g2 < tg2 || e2 < te2 * g2) begin
      r.heading = '0;
      r.degenerate = 1'b1;
      return r;
    end
    r.degenerate = 1'b0;
    ny = az * ex - ax * ez;
    if (ey == 0 && ny == 0) begin
      r.heading = '0;
      return r;
    end
    ang = cordic_turn(ny, ey);
    rnd = {1'b0, ang} + 33'(1 << 15);
    r.heading = rnd[31:16];
    return r;
  endfunction

  task automatic write_reg(tccc_pkg::cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == tccc_pkg::CFG_MIN_GRAVITY_NORM) grav_min = val;
    else east_min = val;
  endtask

  // Present one beat; called at a falling edge, returns at a falling edge
  task automatic send_pair(tccc_pkg::sample_t s);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.accel_x <= s.ax;
    in_if.accel_y <= s.ay;
    in_if.accel_z <= s.az;
    in_if.field_x <= s.mx;
    in_if.field_y <= s.my;
    in_if.field_z <= s.mz;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    heading_q.push_back(predict_heading(s));
    @(negedge clk_i);
  endtask

  // Drop valid at once, then wait for every expected beat
  task automatic drain_all();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (heading_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  function automatic tccc_pkg::sample_t rand_pair();
    tccc_pkg::sample_t s;
    int m;
    m = $urandom_range(3);
    s = tccc_pkg::sample_t'({$urandom, $urandom, $urandom});
    if (m == 0) begin
      // realistic magnitudes: about 1 g and some tens of microtesla
      s.ax = $signed(16'($urandom_range(5000))) - 16'sd2500;
      s.ay = $signed(16'($urandom_range(5000))) - 16'sd2500;
      s.az = $signed(16'($urandom_range(5000))) - 16'sd2500;
      s.mx = $signed(16'($urandom_range(2000))) - 16'sd1000;
      s.my = $signed(16'($urandom_range(2000))) - 16'sd1000;
      s.mz = $signed(16'($urandom_range(2000))) - 16'sd1000;
    end else if (m == 1) begin
      // tiny vectors to hit the norm tests
      s.ax = $signed(16'($urandom_range(8))) - 16'sd4;
      s.ay = $signed(16'($urandom_range(8))) - 16'sd4;
      s.az = $signed(16'($urandom_range(8))) - 16'sd4;
      s.mx = $signed(16'($urandom_range(8))) - 16'sd4;
      s.my = $signed(16'($urandom_range(8))) - 16'sd4;
      s.mz = $signed(16'($urandom_range(8))) - 16'sd4;
    end
    return s;
  endfunction

  // Output side: stall at random, check each beat
  initial begin
    heading_t want;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 13);
      end
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (heading_q.size() == 0) begin
          $error("heading beat with nothing expected");
          errors++;
        end else begin
          want = heading_q.pop_front();
          if (out_if.heading !== want.heading) begin
            $error("heading: expected %0d, got %0d", want.heading, out_if.heading);
            errors++;
          end
          if (out_if.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, got %0d", want.degenerate,
                   out_if.degenerate);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    heading_t  got_want;
    logic [15:0] grav_set[4];
    logic [15:0] east_set[4];
    errors = 0; no_idle = 1'b0; hold_off = 0;
    grav_min = 16'd1; east_min = 16'd1;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = tccc_pkg::CFG_MIN_GRAVITY_NORM;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.accel_x = '0; in_if.accel_y = '0; in_if.accel_z = '0;
    in_if.field_x = '0; in_if.field_y = '0; in_if.field_z = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table under reset thresholds: zero vectors are degenerate
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 1'b1}});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                     '{16'd0, 1'b1}});
    // field along gravity: no east vector
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd100}, 1'b1,
                     '{16'd0, 1'b1}});
    // level device, field north/east/south/west
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd2500, 16'sd0, 16'sd300, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd2500, 16'sd300, 16'sd0, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd2500, 16'sd0, -16'sd300, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd2500, -16'sd300, 16'sd0, 16'sd0}, 1'b0, '0});
    // gravity along y: both angle operands vanish
    rows.push_back('{'{16'sd0, 16'sd2500, 16'sd0, 16'sd300, 16'sd10, 16'sd0}, 1'b1,
                     '{16'd0, 1'b0}});
    // extremes
    rows.push_back('{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0, '0});
    rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0, '0});
    rows.push_back('{'{16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF, 16'h7FFF}, 1'b0, '0});
    rows.push_back('{'{16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001}, 1'b0, '0});
    rows.push_back('{'{16'h0001, 16'hFFFF, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF}, 1'b0, '0});
    rows.push_back('{'{16'h0001, 16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0000}, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.chk) begin
        got_want = predict_heading(row.smp);
        if (got_want !== row.want) begin
          $error("table row %0d: predictor disagrees", i);
          errors++;
        end
      end
      send_pair(row.smp);
    end
    drain_all();

    // Zero thresholds: nothing degenerate, zero vectors reach the angle path
    write_reg(tccc_pkg::CFG_MIN_GRAVITY_NORM, 16'd0);
    write_reg(tccc_pkg::CFG_MIN_EAST_NORM, 16'd0);
    foreach (rows[i]) send_pair(rows[i].smp);
    drain_all();

    // Random phases across threshold settings
    grav_set = '{16'd0, 16'd1, 16'd300, 16'hFFFF};
    east_set = '{16'd0, 16'd1, 16'd40, 16'hFFFF};
    for (int p = 0; p < 6; p++) begin
      if (p < 4) begin
        write_reg(tccc_pkg::CFG_MIN_GRAVITY_NORM, grav_set[p]);
        write_reg(tccc_pkg::CFG_MIN_EAST_NORM, east_set[(p + 1) % 4]);
      end else begin
        write_reg(tccc_pkg::CFG_MIN_GRAVITY_NORM, 16'($urandom_range(3000)));
        write_reg(tccc_pkg::CFG_MIN_EAST_NORM, 16'($urandom_range(200)));
      end
      no_idle = (p == 2);
      if (p == 1) hold_off = 200;
      for (int n = 0; n < 250; n++) send_pair(rand_pair());
      drain_all();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
